// File: design/continued_fraction_approximator_defines.svh
// Assertion macros shared by the checker of the continued fraction approximator.
// No dependencies; included by design/cfa_checker.sv.
`ifndef CONTINUED_FRACTION_APPROXIMATOR_DEFINES_SVH
`define CONTINUED_FRACTION_APPROXIMATOR_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define CFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfa check failed");

// Next-cycle implication, off while reset is held.
`define CFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfa check failed");

// Next-cycle implication that stays live through reset.
`define CFA_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cfa check failed");

`endif

// File: design/cfa_pkg.sv
// Shared types and constants of the continued fraction approximator.
// No dependencies; used by the top level and the checker.
package cfa_pkg;

    localparam int INT_W       = 31;
    localparam int FRAC_W      = 32;
    localparam int NUM_W       = 63;
    localparam int DEN_W       = 33;
    localparam int TOL_W       = 32;
    localparam int MAX_RESULTS = 48;
    localparam int CNT_W       = 6;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd4000000000;

    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
    } t_cfa_in;

    typedef struct packed {
        logic [NUM_W-1:0] numerator;
        logic [DEN_W-1:0] denominator;
        logic             exact;
        logic             last;
    } t_cfa_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_DIV,
        ST_ADD,
        ST_CHK,
        ST_EMIT
    } t_cfa_state;

endpackage

// File: design/cfa_div_mac.sv
// Bit-serial restoring divider that also accumulates quotient * two multiplicands.
// No dependencies; instantiated by continued_fraction_approximator.
module cfa_div_mac #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    input  logic [W-1:0] i_mcand_a,
    input  logic [W-1:0] i_mcand_b,
    output logic         o_done,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_prod_a,
    output logic [W-1:0] o_prod_b
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_sh;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_acc_a;
    logic [W-1:0]  r_acc_b;

    logic [W:0]    w_trial;
    logic [W:0]    w_sub;
    logic          w_ge;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_acc_a;
    logic [W-1:0]  n_acc_b;

    // one quotient bit per cycle, MSB first; divisor and multiplicands hold during a run
    always_comb begin
        w_trial = {r_rem, r_sh[W-1]};
        w_sub   = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        n_rem   = w_ge ? w_sub[W-1:0] : w_trial[W-1:0];
        n_acc_a = (r_acc_a << 1) + (w_ge ? i_mcand_a : '0);
        n_acc_b = (r_acc_b << 1) + (w_ge ? i_mcand_b : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh    <= i_dividend;
            r_rem   <= '0;
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_busy) begin
            r_sh    <= r_sh << 1;
            r_rem   <= n_rem;
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
        end
    end

    assign o_done   = r_done;
    assign o_rem    = r_rem;
    assign o_prod_a = r_acc_a;
    assign o_prod_b = r_acc_b;

endmodule

// File: design/continued_fraction_approximator.sv
// Continued fraction approximator. Takes int_part + frac_part / 2^FRAC_BITS and
// expands the fraction by Euclid steps, emitting each convergent p/q as
// numerator = int_part * q + p and denominator = q, starting with 1/a1. The
// sequence ends with last set on the first convergent whose relative error is
// within 1/tolerance_inverse, on an exact convergent (exact set), or on the
// 48th result; a zero fraction gives int_part/1 alone. One input transaction is
// worked at a time and o_in_stall stays high until its last result has been
// written to the output register; that register lets the next input
// transaction be taken while the final result still waits downstream. For
// each result a bit-serial divider produces the partial quotient and the new
// convergent products one bit a cycle, then a second bit-serial pass does the
// exact error test and forms int_part * q. tolerance_inverse is written through
// i_cfg_we / i_cfg_data; the user must do so only while the block is idle, as
// the block itself does not enforce it. A value of zero ends every expansion
// at its first convergent.
// Depends on cfa_pkg and cfa_div_mac.
module continued_fraction_approximator
    import cfa_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_cfa_in          i_in_data,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_cfa_out         o_out_data,
    // tolerance_inverse write port
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_data
);

    // every convergent term is bounded by 2^FRAC_BITS
    localparam int DW     = FRAC_BITS + 1;
    // check pass length covers both q and int_part
    localparam int L      = (DW > INT_W) ? DW : INT_W;
    // signed f*q - r*tol never reaches 2^(L+32) in magnitude
    localparam int DIFF_W = L + TOL_W + 1;
    localparam int BIT_W  = $clog2(L + 1);

    localparam logic [DW-1:0]   DIVIDEND_INIT = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_W:0] FMASK_X = (FRAC_BITS >= FRAC_W) ?
        {(FRAC_W + 1){1'b1}} :
        ((FRAC_W + 1)'(1) << FRAC_BITS) - (FRAC_W + 1)'(1);

    t_cfa_state r_state, n_state;

    logic [TOL_W-1:0]  r_tol;
    t_cfa_in           r_in;
    logic [FRAC_W-1:0] r_frac;

    // convergent pair and Euclid pair
    logic [DW-1:0]     r_prev_num, r_cur_num;
    logic [DW-1:0]     r_prev_den, r_cur_den;
    logic [DW-1:0]     r_dividend, r_divisor;
    logic [CNT_W-1:0]  r_res_cnt;

    // check pass shift registers
    logic [L-1:0]      r_ck_q, r_ck_r, r_ck_i;
    logic [DIFF_W-1:0] r_diff, n_diff;
    logic [NUM_W-1:0]  r_nacc, n_nacc;
    logic [BIT_W-1:0]  r_bit;

    logic              r_out_valid;
    t_cfa_out          r_out;
    t_cfa_out          w_out;

    logic [FRAC_W-1:0] w_frac;
    logic [DW-1:0]     w_np, w_nq;
    logic              w_exact, w_done;

    logic              in_fire, div_start, emit_fire;
    logic              div_done;
    logic [DW-1:0]     div_rem, div_prod_num, div_prod_den;

    // partial quotient a, a*cur_num and a*cur_den all come out of one serial run
    cfa_div_mac #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .i_mcand_a  (r_cur_num),
        .i_mcand_b  (r_cur_den),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod_a   (div_prod_num),
        .o_prod_b   (div_prod_den)
    );

    always_comb begin
        w_frac  = r_in.frac_part & FMASK_X[FRAC_W-1:0];
        w_np    = div_prod_num + r_prev_num;
        w_nq    = div_prod_den + r_prev_den;

        // error test r*tol <= f*q, MSB first over bits of q and r
        n_diff  = (r_diff << 1)
                + (r_ck_q[L-1] ? DIFF_W'(r_frac) : '0)
                - (r_ck_r[L-1] ? DIFF_W'(r_tol) : '0);
        // int_part * q, wraps at the numerator width
        n_nacc  = (r_nacc << 1) + (r_ck_i[L-1] ? NUM_W'(r_cur_den) : '0);

        w_exact = (r_divisor == '0);
        w_done  = w_exact || !r_diff[DIFF_W-1] ||
                  (r_res_cnt == CNT_W'(MAX_RESULTS - 1));

        w_out.numerator   = r_nacc + NUM_W'(r_cur_num);
        w_out.denominator = DEN_W'(r_cur_den);
        w_out.exact       = w_exact;
        w_out.last        = w_done;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = (w_frac == '0) ? ST_CHK : ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_ADD;
            ST_ADD:   n_state = ST_CHK;
            ST_CHK:   if (r_bit == BIT_W'(1)) n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = w_done ? ST_IDLE : ST_START;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        in_fire    = (r_state == ST_IDLE) && i_in_valid;
        div_start  = (r_state == ST_START);
        // output slot is free now or frees at this edge
        emit_fire  = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_in <= i_in_data;
                end
            end
            ST_LOAD: begin
                // convergents start at 1/0 and 0/1; a zero fraction goes straight
                // to the check pass with q = 1, r = 0
                r_frac     <= w_frac;
                r_prev_num <= DW'(1);
                r_prev_den <= '0;
                r_cur_num  <= '0;
                r_cur_den  <= DW'(1);
                r_dividend <= DIVIDEND_INIT;
                r_divisor  <= DW'(w_frac);
                r_res_cnt  <= '0;
                r_ck_q     <= L'(1);
                r_ck_r     <= '0;
                r_ck_i     <= L'(r_in.int_part);
                r_diff     <= '0;
                r_nacc     <= '0;
                r_bit      <= BIT_W'(L);
            end
            ST_ADD: begin
                r_prev_num <= r_cur_num;
                r_cur_num  <= w_np;
                r_prev_den <= r_cur_den;
                r_cur_den  <= w_nq;
                r_dividend <= r_divisor;
                r_divisor  <= div_rem;
                r_ck_q     <= L'(w_nq);
                r_ck_r     <= L'(div_rem);
                r_ck_i     <= L'(r_in.int_part);
                r_diff     <= '0;
                r_nacc     <= '0;
                r_bit      <= BIT_W'(L);
            end
            ST_CHK: begin
                r_ck_q <= r_ck_q << 1;
                r_ck_r <= r_ck_r << 1;
                r_ck_i <= r_ck_i << 1;
                r_diff <= n_diff;
                r_nacc <= n_nacc;
                r_bit  <= r_bit - BIT_W'(1);
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    r_out     <= w_out;
                    r_res_cnt <= r_res_cnt + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/cfa_checker.sv
// Port-level checker for the continued fraction approximator, bound to the top.
// Depends on cfa_pkg and continued_fraction_approximator_defines.svh.
`include "continued_fraction_approximator_defines.svh"

module cfa_checker
    import cfa_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_cfa_out o_out_data
);

    // reset empties the output register
    `CFA_ASSERT_NEXT_ANY(a_reset_clears, i_clk, !i_rst_n, !o_out_valid)

    // a stalled result transaction holds
    `CFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // an accepted input transaction keeps the engine busy
    `CFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // while a non-final convergent waits, more of the same expansion is pending
    `CFA_ASSERT_SAME(a_more_pending, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_in_stall)

endmodule

bind continued_fraction_approximator cfa_checker u_cfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: sim/tb_continued_fraction_approximator.sv
// Self-checking testbench for continued_fraction_approximator: directed and random fractions
// under several tolerance settings, random idling on both channels and a long output hold.
// Depends on design/cfa_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_continued_fraction_approximator;
    import cfa_pkg::*;

    // Pacing of the random idling and of the long output hold.
    localparam int GAP_MAX       = 12;
    localparam int LONG_HOLD     = 600;
    localparam int DRAIN_PAUSE   = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int REPORT_MAX    = 10;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 56;

    // Golden-ratio fraction: its leading partial quotients are 1, giving a long expansion.
    localparam logic [FRAC_W-1:0] FRAC_GOLDEN = 32'h9E37_79B9;
    // Fraction of pi, an irregular expansion with one large partial quotient.
    localparam logic [FRAC_W-1:0] FRAC_PI     = 32'h243F_6A88;

    // DUT-facing signals; every input starts at a known value.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_cfa_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_cfa_out         o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [TOL_W-1:0] i_cfg_data  = '0;

    // Predictor copy of the tolerance register, and the convergents still owed by the block.
    logic [TOL_W-1:0] tol_inv = TOL_RESET;
    t_cfa_out         convergent_q[$];

    // Idling switches and the long hold request picked up by the sink process.
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_req     = 0;

    // Run bookkeeping.
    int err_count     = 0;
    int items_sent    = 0;
    int conv_checked  = 0;
    int tol_writes    = 0;

    continued_fraction_approximator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: far beyond a run where every input expands to the step cap and every
    // convergent waits out the longest output stall.
    initial begin
        #(24_000_000);
        $display("tb_continued_fraction_approximator: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: Euclid expansion of F / 2^FRAC_W on the pair (2^FRAC_W, F).
    // After each step the convergent p/q is owed as int*q + p over q. The
    // expansion ends on a zero remainder, on the error test r*tol <= F*q
    // (full 128-bit products, so nothing is lost), or at the step cap.
    // ------------------------------------------------------------------------
    function automatic void expand_fraction(input t_cfa_in item);
        logic [63:0]  whole, frac, num_prev, num_cur, den_prev, den_cur;
        logic [63:0]  dividend, divisor, quot, rem, num_next, den_next, full_num;
        logic [127:0] err_lhs, err_rhs;
        bit           done;
        int           steps;
        t_cfa_out     conv;
        whole = 64'(item.int_part);
        frac  = 64'(item.frac_part);
        if (frac == 0) begin
            // zero fraction: the integer alone, exact
            conv.numerator   = whole[NUM_W-1:0];
            conv.denominator = DEN_W'(1);
            conv.exact       = 1'b1;
            conv.last        = 1'b1;
            convergent_q.push_back(conv);
        end else begin
            num_prev = 64'd1;
            den_prev = 64'd0;
            num_cur  = 64'd0;
            den_cur  = 64'd1;
            dividend = 64'd1 << FRAC_W;
            divisor  = frac;
            steps    = 0;
            done     = 1'b0;
            while (!done) begin
                quot     = dividend / divisor;
                rem      = dividend % divisor;
                num_next = quot * num_cur + num_prev;
                den_next = quot * den_cur + den_prev;
                num_prev = num_cur;
                num_cur  = num_next;
                den_prev = den_cur;
                den_cur  = den_next;
                dividend = divisor;
                divisor  = rem;
                steps++;
                err_lhs  = 128'(rem) * 128'(tol_inv);
                err_rhs  = 128'(frac) * 128'(den_next);
                done     = (rem == 0) || (err_lhs <= err_rhs) || (steps >= MAX_RESULTS);
                // 64-bit wrap, then cut to the port width
                full_num = whole * den_next + num_next;
                conv.numerator   = full_num[NUM_W-1:0];
                conv.denominator = den_next[DEN_W-1:0];
                conv.exact       = (rem == 0);
                conv.last        = done;
                convergent_q.push_back(conv);
            end
        end
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string fld, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
            note_error($sformatf("convergent %0d %s expected %0h actual %0h",
                                 conv_checked, fld, want, got));
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every output transaction is matched against the oldest
    // owed convergent. Sampled at the edge, before the DUT's updates land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cfa_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (convergent_q.size() == 0) begin
                note_error($sformatf("unexpected convergent num %0h den %0h",
                                     o_out_data.numerator, o_out_data.denominator));
            end else begin
                want = convergent_q.pop_front();
                check_field("numerator", 64'(want.numerator), 64'(o_out_data.numerator));
                check_field("denominator", 64'(want.denominator),
                            64'(o_out_data.denominator));
                check_field("exact", 64'(want.exact), 64'(o_out_data.exact));
                check_field("last", 64'(want.last), 64'(o_out_data.last));
            end
            conv_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Output stall pacing: random bursts, or one long hold when a test asks.
    // The long hold is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int span;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                span     = hold_req;
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                span = $urandom_range(1, GAP_MAX);
                i_out_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one input transaction, with an optional idle burst first. Returns
    // in the time step of the accepting edge; valid stays high for a following
    // transaction so back-to-back items see no bubble.
    task automatic push_sample(input logic [INT_W-1:0] whole, input logic [FRAC_W-1:0] frac);
        t_cfa_in item;
        item.int_part  = whole;
        item.frac_part = frac;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        expand_fraction(item);
        items_sent++;
    endtask

    // Drop valid, wait for every owed convergent, then a short settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (convergent_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Tolerance write, only with the block drained; the predictor follows.
    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tol_inv    = value;
        tol_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset tolerance: zero fraction, field extremes, exact dyadic cases,
    // and the widest numerator.
    task automatic test_reset_tolerance();
        push_sample('0, '0);
        push_sample('1, '0);
        push_sample('0, 32'd1);                  // a1 = 2^32, largest denominator
        push_sample('1, 32'd1);                  // widest numerator
        push_sample('0, '1);
        push_sample('1, '1);
        push_sample(31'h2AAA_AAAA, 32'h8000_0000);
        push_sample(31'h5555_5555, 32'hAAAA_AAAA);
        push_sample('0, 32'h5555_5555);
        push_sample(31'd3, FRAC_GOLDEN);
    endtask

    // Tolerance extremes: tightest gives the longest expansions, loosest and zero
    // stop at the first convergent.
    task automatic test_tolerance_extremes();
        set_tolerance('1);
        push_sample('0, FRAC_GOLDEN);
        push_sample(31'd3, FRAC_PI);
        push_sample('1, FRAC_GOLDEN);
        set_tolerance(TOL_W'(1));
        push_sample(31'd3, FRAC_PI);
        push_sample('0, 32'h0000_0003);
        set_tolerance('0);
        push_sample('0, FRAC_GOLDEN);
        push_sample(31'd7, 32'h7FFF_FFFF);
        push_sample('1, '0);
    endtask

    // Long output hold while inputs keep coming: the output register fills
    // and the block has to stall its input side.
    task automatic test_output_backpressure();
        set_tolerance(TOL_RESET);
        hold_req = LONG_HOLD;
        push_sample(31'd1, FRAC_GOLDEN);
        push_sample(31'd2, FRAC_PI);
        push_sample('0, 32'h1234_5678);
        push_sample(31'h0ABC_DEF0, 32'hFFFF_0001);
    endtask

    // Random fractions across several tolerance settings. The last phase has
    // no idling on either side.
    task automatic test_random_expansions();
        logic [TOL_W-1:0]  tol;
        logic [INT_W-1:0]  whole;
        logic [FRAC_W-1:0] frac;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0:       tol = TOL_W'($urandom_range(1, 1000));
                1:       tol = TOL_W'($urandom);
                2:       tol = TOL_RESET;
                3:       tol = '1;
                default: tol = TOL_W'($urandom_range(1 << 16, 1 << 28));
            endcase
            set_tolerance(tol);
            if (phase == RAND_PHASES - 1) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0:       frac = '0;
                    1:       frac = FRAC_W'($urandom_range(1, 255));
                    // dyadic fractions end exactly after few steps
                    2:       frac = FRAC_W'($urandom) & ~((32'd1 << $urandom_range(0, 24)) - 1);
                    default: frac = FRAC_W'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       whole = '0;
                    1:       whole = '1;
                    default: whole = INT_W'($urandom);
                endcase
                push_sample(whole, frac);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tolerance();
        test_tolerance_extremes();
        test_output_backpressure();
        test_random_expansions();

        // all owed convergents in, then watch a while for strays
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (convergent_q.size() != 0)
            note_error($sformatf("%0d convergents never arrived", convergent_q.size()));

        $display("Run: %0d inputs expanded, %0d convergents checked, %0d tolerance writes",
                 items_sent, conv_checked, tol_writes);
        $display("Covered: zero/exact/wide cases, tolerance 0..max, long output hold; %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("tb_continued_fraction_approximator: clean");
        else
            $display("tb_continued_fraction_approximator: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cfa_pkg.sv
design/cfa_div_mac.sv
design/continued_fraction_approximator.sv
design/cfa_checker.sv
sim/tb_continued_fraction_approximator.sv
